FILE: rtl/usts_pkg.sv
// Package for the unit suffix token scanner.
// Holds sizes, types, character class functions and the reserved word table.
// Depends on nothing.
`default_nettype none

package usts_pkg;

  localparam int WORD_CAP   = 15;
  localparam int COUNT_MAX  = 255;
  localparam int WL_W       = $clog2(WORD_CAP + 1);
  localparam int WIDX_W     = $clog2(WORD_CAP);
  localparam int RSV_NUM    = 24;
  localparam int RSV_MAXLEN = 8;

  localparam logic [7:0] CNT_LIMIT = (COUNT_MAX > 255) ? 8'd255 : 8'(COUNT_MAX);

  typedef logic [20:0]     cp_t;
  typedef logic [6:0]      ch_t;
  typedef logic [7:0]      cnt_t;
  typedef logic [WL_W-1:0] wlen_t;

  localparam cp_t CP_TAB     = 21'h09;
  localparam cp_t CP_SPACE   = 21'h20;
  localparam cp_t CP_PERCENT = 21'h25;
  localparam cp_t CP_LPAREN  = 21'h28;
  localparam cp_t CP_RPAREN  = 21'h29;
  localparam cp_t CP_STAR    = 21'h2A;
  localparam cp_t CP_PLUS    = 21'h2B;
  localparam cp_t CP_MINUS   = 21'h2D;
  localparam cp_t CP_DOT     = 21'h2E;
  localparam cp_t CP_SLASH   = 21'h2F;
  localparam cp_t CP_CARET   = 21'h5E;
  localparam cp_t CP_USCORE  = 21'h5F;
  localparam cp_t CP_DEGREE  = 21'h00B0;
  localparam cp_t CP_MIDDOT  = 21'h00B7;
  localparam cp_t CP_ASCII_END = 21'h80;

  // Reserved words, right aligned with eight bits per character.
  localparam logic [8*RSV_MAXLEN-1:0] RSV_TXT [RSV_NUM] = '{
    64'("if"), 64'("then"), 64'("elseif"), 64'("else"), 64'("end"),
    64'("begin"), 64'("and"), 64'("or"), 64'("not"), 64'("mod"),
    64'("nil"), 64'("true"), 64'("false"), 64'("where"), 64'("match"),
    64'("case"), 64'("const"), 64'("in"), 64'("unit"), 64'("input"),
    64'("as"), 64'("unitless"), 64'("desc"), 64'("test")
  };

  localparam logic [3:0] RSV_LEN [RSV_NUM] = '{
    4'd2, 4'd4, 4'd6, 4'd4, 4'd3, 4'd5, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5, 4'd2, 4'd8, 4'd4, 4'd4
  };

  function automatic logic is_start(input cp_t c);
    return c inside {[21'h41:21'h5A], [21'h61:21'h7A], [21'h00C0:21'h024F],
                     [21'h0370:21'h03FF], [21'h0400:21'h04FF], CP_PERCENT,
                     CP_DEGREE};
  endfunction

  function automatic logic is_numeral(input cp_t c);
    return c inside {[21'h30:21'h39]};
  endfunction

  function automatic logic is_part(input cp_t c);
    return is_start(c) || is_numeral(c) || (c == CP_USCORE);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/usts_rsv_match.sv
// Reserved word matcher: compares the stored atom characters with the table.
// Depends on usts_pkg.
`default_nettype none

module usts_rsv_match
  import usts_pkg::*;
(
  input  ch_t   chars [WORD_CAP],
  input  wlen_t len,
  output logic  hit
);

  always_comb begin
    logic m;
    hit = 1'b0;
    for (int i = 0; i < RSV_NUM; i++) begin
      m = (len == WL_W'(RSV_LEN[i]));
      for (int k = 0; k < RSV_MAXLEN; k++) begin
        if ((k < int'(RSV_LEN[i])) &&
            (chars[k] != RSV_TXT[i][(int'(RSV_LEN[i]) - 1 - k) * 8 +: 7])) begin
          m = 1'b0;
        end
      end
      if (m) begin
        hit = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/unit_suffix_token_scanner_top.sv
// Top level of the unit suffix token scanner: input register, scan logic,
// result register. Depends on usts_pkg and usts_rsv_match.
// A result word passes two registers: the input word that decides the scan is
// held in the input register, and its result in the result register.
// Throughput: one input word per cycle; the input side stalls only while the
// result register holds a stalled word and the input register is full.
// Reset is synchronous and active low; it returns the scanner to idle with
// both registers empty. The stored atom characters are not cleared.
`default_nettype none

module unit_suffix_token_scanner_top
  import usts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_start_req,
  input  logic in_unit_allowed,
  input  logic [20:0] in_code_point,
  input  logic in_at_end,
  output logic out_valid,
  input  logic out_stall,
  output logic out_verdict,
  output logic [7:0] out_skipped,
  output logic [7:0] out_token_length,
  output logic out_overflow
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SKIP    = 4'd1;
  localparam logic [3:0] PH_ATOM    = 4'd2;
  localparam logic [3:0] PH_CARET   = 4'd3;
  localparam logic [3:0] PH_EPAREN  = 4'd4;
  localparam logic [3:0] PH_ESIGN   = 4'd5;
  localparam logic [3:0] PH_EINT    = 4'd6;
  localparam logic [3:0] PH_EFRAC   = 4'd7;
  localparam logic [3:0] PH_ESLASH  = 4'd8;
  localparam logic [3:0] PH_EDEN    = 4'd9;
  localparam logic [3:0] PH_ECLOSE  = 4'd10;
  localparam logic [3:0] PH_DONE    = 4'd11;
  localparam logic [3:0] PH_AFTEROP = 4'd12;

  // Input register.
  logic s1_valid_r;
  logic s1_start_req_r;
  logic s1_unit_allowed_r;
  cp_t  s1_code_point_r;
  logic s1_at_end_r;

  // Scan state.
  logic [3:0] phase_r, phase_nxt;
  cnt_t  skip_r, skip_nxt;
  cnt_t  cons_r, cons_nxt;
  cnt_t  mark_r, mark_nxt;
  wlen_t wlen_r, wlen_nxt;
  logic  ascii_r, ascii_nxt;
  logic  first_r, first_nxt;
  logic  ovf_r, ovf_nxt;
  ch_t   chars_r [WORD_CAP];

  // Result register.
  logic out_valid_r;
  logic out_verdict_r;
  cnt_t out_skipped_r;
  cnt_t out_token_length_r;
  logic out_overflow_r;

  logic  fire;
  logic  in_take;
  logic  rsv_hit;
  logic  emit;
  logic  accept_tok;
  logic  wr_en;
  wlen_t wr_idx;
  ch_t   wr_char;
  cp_t   c;

  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_take  = !s1_valid_r || fire;
  assign in_stall = !in_take;

  usts_rsv_match u_rsv (
    .chars (chars_r),
    .len   (wlen_r),
    .hit   (rsv_hit)
  );

  always_comb begin
    logic done;
    logic do_cons;
    logic do_atom;
    logic do_skip;
    done       = 1'b0;
    do_cons    = 1'b0;
    do_atom    = 1'b0;
    do_skip    = 1'b0;
    emit       = 1'b0;
    accept_tok = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = '0;
    c          = s1_at_end_r ? '0 : s1_code_point_r;
    wr_char    = c[6:0];
    phase_nxt  = phase_r;
    skip_nxt   = skip_r;
    cons_nxt   = cons_r;
    mark_nxt   = mark_r;
    wlen_nxt   = wlen_r;
    ascii_nxt  = ascii_r;
    first_nxt  = first_r;
    ovf_nxt    = ovf_r;

    if (s1_start_req_r) begin
      skip_nxt  = '0;
      cons_nxt  = '0;
      mark_nxt  = '0;
      wlen_nxt  = '0;
      ascii_nxt = 1'b1;
      first_nxt = 1'b1;
      ovf_nxt   = 1'b0;
      if (!s1_unit_allowed_r) begin
        emit      = 1'b1;
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = PH_SKIP;
      end
    end

    if (!done && ((phase_nxt == PH_IDLE) || (phase_nxt > PH_AFTEROP))) begin
      phase_nxt = PH_IDLE;
      done      = 1'b1;
    end

    if (!done && phase_nxt == PH_SKIP) begin
      done = 1'b1;
      if (c == CP_SPACE || c == CP_TAB) begin
        do_skip = 1'b1;
      end else if (is_start(c)) begin
        do_atom   = 1'b1;
        phase_nxt = PH_ATOM;
      end else begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
      end
    end

    if (!done && phase_nxt == PH_ATOM) begin
      if (is_part(c)) begin
        do_atom = 1'b1;
        done    = 1'b1;
      end else begin
        phase_nxt = PH_CARET;
      end
    end

    if (!done && phase_nxt == PH_CARET) begin
      if (c == CP_CARET) begin
        do_cons = 1'b1; done = 1'b1; phase_nxt = PH_EPAREN;
      end else begin
        phase_nxt = PH_DONE;
      end
    end

    if (!done && phase_nxt == PH_EPAREN) begin
      if (c == CP_LPAREN) begin
        do_cons = 1'b1; done = 1'b1;
      end
      phase_nxt = PH_ESIGN;
    end

    if (!done && phase_nxt == PH_ESIGN) begin
      if (c == CP_PLUS || c == CP_MINUS) begin
        do_cons = 1'b1; done = 1'b1;
      end
      phase_nxt = PH_EINT;
    end

    if (!done && phase_nxt == PH_EINT) begin
      if (is_numeral(c)) begin
        do_cons = 1'b1; done = 1'b1;
      end else if (c == CP_DOT) begin
        do_cons = 1'b1; done = 1'b1; phase_nxt = PH_EFRAC;
      end else begin
        phase_nxt = PH_ESLASH;
      end
    end

    if (!done && phase_nxt == PH_EFRAC) begin
      if (is_numeral(c)) begin
        do_cons = 1'b1; done = 1'b1;
      end else begin
        phase_nxt = PH_ESLASH;
      end
    end

    if (!done && phase_nxt == PH_ESLASH) begin
      if (c == CP_SLASH) begin
        do_cons = 1'b1; done = 1'b1; phase_nxt = PH_EDEN;
      end else begin
        phase_nxt = PH_ECLOSE;
      end
    end

    if (!done && phase_nxt == PH_EDEN) begin
      if (is_numeral(c)) begin
        do_cons = 1'b1; done = 1'b1;
      end else begin
        phase_nxt = PH_ECLOSE;
      end
    end

    if (!done && phase_nxt == PH_ECLOSE) begin
      if (c == CP_RPAREN) begin
        do_cons = 1'b1; done = 1'b1;
      end
      phase_nxt = PH_DONE;
    end

    if (!done && phase_nxt == PH_DONE) begin
      done     = 1'b1;
      mark_nxt = cons_r;
      if (c == CP_STAR || c == CP_MIDDOT || c == CP_SLASH) begin
        do_cons   = 1'b1;
        first_nxt = 1'b0;
        phase_nxt = PH_AFTEROP;
      end else begin
        emit       = 1'b1;
        accept_tok = !(first_r && ascii_r && rsv_hit);
        phase_nxt  = PH_IDLE;
      end
    end

    if (!done && phase_nxt == PH_AFTEROP) begin
      done = 1'b1;
      if (is_start(c)) begin
        do_atom   = 1'b1;
        phase_nxt = PH_ATOM;
      end else begin
        emit       = 1'b1;
        accept_tok = 1'b1;
        phase_nxt  = PH_IDLE;
      end
    end

    // Skip and consumed counts never both move for one word; an atom may move the
    // word length too. They build on the values after a start word has cleared them.
    if (do_atom) begin
      do_cons = 1'b1;
      if (c < CP_ASCII_END) begin
        if (wlen_nxt < WL_W'(WORD_CAP)) begin
          wr_en    = 1'b1;
          wr_idx   = wlen_nxt;
          wlen_nxt = wlen_nxt + 1'b1;
        end
      end else begin
        ascii_nxt = 1'b0;
      end
    end

    if (do_cons) begin
      if (cons_nxt >= CNT_LIMIT) begin
        ovf_nxt = 1'b1;
      end else begin
        cons_nxt = cons_nxt + 1'b1;
      end
    end

    if (do_skip) begin
      if (skip_nxt >= CNT_LIMIT) begin
        ovf_nxt = 1'b1;
      end else begin
        skip_nxt = skip_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      s1_start_req_r    <= in_start_req;
      s1_unit_allowed_r <= in_unit_allowed;
      s1_code_point_r   <= in_code_point;
      s1_at_end_r       <= in_at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      skip_r  <= '0;
      cons_r  <= '0;
      mark_r  <= '0;
      wlen_r  <= '0;
      ascii_r <= 1'b1;
      first_r <= 1'b1;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      cons_r  <= cons_nxt;
      mark_r  <= mark_nxt;
      wlen_r  <= wlen_nxt;
      ascii_r <= ascii_nxt;
      first_r <= first_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      chars_r[wr_idx[WIDX_W-1:0]] <= wr_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_verdict_r      <= accept_tok;
      out_skipped_r      <= skip_nxt;
      out_token_length_r <= accept_tok ? mark_nxt : '0;
      out_overflow_r     <= ovf_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_skipped      = out_skipped_r;
  assign out_token_length = out_token_length_r;
  assign out_overflow     = out_overflow_r;

  a_mark_le_cons: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= cons_r)
    else $error("marked length exceeds consumed count");

  a_wlen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= WL_W'(WORD_CAP))
    else $error("word length beyond capacity");

  a_accept_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r |-> out_token_length_r != '0)
    else $error("accepted token with zero length");

  a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_verdict_r |-> out_token_length_r == '0)
    else $error("rejected word carries a token length");

  a_no_fire_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !fire |=> s1_valid_r && $stable(s1_code_point_r))
    else $error("input register lost a pending word");

endmodule

`default_nettype wire
